// ===== rtl/fpqr_pkg.sv =====
package fpqr_pkg;

    localparam int QueueDepth = 256;
    localparam int QueueAw    = 8;
    localparam int RecDepth   = 4096;
    localparam int RecAw      = 12;
    localparam int ReadBurst  = 20;
    localparam int BurstW     = 6;

    localparam logic [47:0] NeutralSticks = 48'h8008_0080_0800;
    localparam logic [7:0]  RunCap        = 8'd240;
    localparam logic [4:0]  StarveLimit   = 5'd20;

    typedef enum logic [2:0] {
        CMD_QUEUE_DIGITAL = 3'd0,
        CMD_QUEUE_FULL    = 3'd1,
        CMD_FRAME_TICK    = 3'd2,
        CMD_SET_MODE      = 3'd3,
        CMD_START_REC     = 3'd4,
        CMD_STOP_REC      = 3'd5,
        CMD_READ_REC      = 3'd6,
        CMD_NOP           = 3'd7
    } t_cmd;

    localparam logic [1:0] KIND_STATUS = 2'd0;
    localparam logic [1:0] KIND_FRAME  = 2'd1;
    localparam logic [1:0] KIND_REC    = 2'd2;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_TICK_PUSH,
        ST_TICK_SEL,
        ST_TICK_SHOW,
        ST_REC_RD,
        ST_REC_WR,
        ST_SEED,
        ST_RD_ADDR,
        ST_RD_OUT,
        ST_RD_LAST,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic       push_user;
        logic       push_neutral;
        logic       set_mode;
        logic       tick_sel;
        logic       q_read;
        logic       show_frame;
        logic       rec_read;
        logic       rec_write;
        logic       seed;
        logic       stop_rec;
        logic       rd_start;
        logic       rd_issue;
        logic       rd_emit;
        logic       rd_last;
        logic       status_out;
        logic       out_last;
    } t_ctrl;

    typedef struct packed {
        logic starved;
        logic rec_active;
        logic rd_at_end;
        logic rd_next_end;
        logic out_busy;
    } t_stat;

endpackage

// ===== rtl/fpqr_if.sv =====
interface fpqr_in_if;
    logic        valid;
    logic        ready;
    logic [2:0]  command;
    logic [23:0] buttons_in;
    logic [47:0] sticks_in;
    logic        mode_value;
    logic        restart_read;
    modport source (output valid, command, buttons_in, sticks_in, mode_value, restart_read,
                    input ready);
    modport sink   (input valid, command, buttons_in, sticks_in, mode_value, restart_read,
                    output ready);
endinterface

interface fpqr_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [23:0] buttons_out;
    logic [47:0] sticks_out;
    logic [7:0]  run_count;
    logic        last_of_burst;
    logic        more_pending;
    logic        push_accepted;
    logic [7:0]  queue_free;
    logic [12:0] record_remaining;
    logic        buffered_mode;
    logic        recording_on;
    modport source (output valid, kind, buttons_out, sticks_out, run_count, last_of_burst,
                    more_pending, push_accepted, queue_free, record_remaining,
                    buffered_mode, recording_on, input ready);
    modport sink   (input valid, kind, buttons_out, sticks_out, run_count, last_of_burst,
                    more_pending, push_accepted, queue_free, record_remaining,
                    buffered_mode, recording_on, output ready);
endinterface

// ===== rtl/fpqr_ctrl.sv =====
module fpqr_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  logic [2:0]           i_cmd,
    output logic                 o_in_ready,
    input  fpqr_pkg::t_stat      i_stat,
    output fpqr_pkg::t_ctrl      o_ctrl
);

    fpqr_pkg::t_state r_state, n_state;
    fpqr_pkg::t_cmd   cmd;
    logic [fpqr_pkg::BurstW-1:0] r_cnt, n_cnt;

    assign cmd = fpqr_pkg::t_cmd'(i_cmd);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= fpqr_pkg::ST_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_cnt      = r_cnt;
        o_ctrl     = '0;
        o_in_ready = 1'b0;
        case (r_state)
            fpqr_pkg::ST_IDLE: begin
                o_in_ready = !i_stat.out_busy;
                if (i_in_valid && !i_stat.out_busy) begin
                    case (cmd)
                        fpqr_pkg::CMD_QUEUE_DIGITAL, fpqr_pkg::CMD_QUEUE_FULL: begin
                            o_ctrl.push_user  = 1'b1;
                            o_ctrl.status_out = 1'b1;
                        end
                        fpqr_pkg::CMD_FRAME_TICK: begin
                            o_ctrl.push_neutral = i_stat.starved;
                            n_state = fpqr_pkg::ST_TICK_SEL;
                        end
                        fpqr_pkg::CMD_SET_MODE: begin
                            o_ctrl.set_mode   = 1'b1;
                            o_ctrl.status_out = 1'b1;
                        end
                        fpqr_pkg::CMD_START_REC: begin
                            o_ctrl.q_read = 1'b1;
                            n_state = fpqr_pkg::ST_SEED;
                        end
                        fpqr_pkg::CMD_STOP_REC: begin
                            o_ctrl.stop_rec   = 1'b1;
                            o_ctrl.status_out = 1'b1;
                        end
                        fpqr_pkg::CMD_READ_REC: begin
                            o_ctrl.rd_start = 1'b1;
                            n_cnt   = '0;
                            n_state = fpqr_pkg::ST_RD_ADDR;
                        end
                        default: o_ctrl.status_out = 1'b1;
                    endcase
                end
            end
            fpqr_pkg::ST_TICK_SEL: begin
                o_ctrl.tick_sel = 1'b1;
                n_state = fpqr_pkg::ST_TICK_SHOW;
            end
            fpqr_pkg::ST_TICK_SHOW: begin
                o_ctrl.q_read = 1'b1;
                n_state = fpqr_pkg::ST_TICK_PUSH;
            end
            fpqr_pkg::ST_TICK_PUSH: begin
                // when recording, the frame is shown once the run update is done
                if (i_stat.rec_active) begin
                    o_ctrl.rec_read = 1'b1;
                    n_state = fpqr_pkg::ST_REC_RD;
                end else if (!i_stat.out_busy) begin
                    o_ctrl.show_frame = 1'b1;
                    n_state = fpqr_pkg::ST_IDLE;
                end
            end
            fpqr_pkg::ST_REC_RD: begin
                n_state = fpqr_pkg::ST_REC_WR;
            end
            fpqr_pkg::ST_REC_WR: begin
                if (!i_stat.out_busy) begin
                    o_ctrl.rec_write  = 1'b1;
                    o_ctrl.show_frame = 1'b1;
                    n_state = fpqr_pkg::ST_IDLE;
                end
            end
            fpqr_pkg::ST_SEED: begin
                if (!i_stat.out_busy) begin
                    o_ctrl.seed       = 1'b1;
                    o_ctrl.status_out = 1'b1;
                    n_state = fpqr_pkg::ST_IDLE;
                end
            end
            fpqr_pkg::ST_RD_ADDR: begin
                o_ctrl.rd_issue = 1'b1;
                n_state = fpqr_pkg::ST_RD_OUT;
            end
            fpqr_pkg::ST_RD_OUT: begin
                if (!i_stat.out_busy) begin
                    if (i_stat.rd_at_end) begin
                        o_ctrl.rd_emit  = 1'b1;
                        o_ctrl.rd_last  = 1'b1;
                        o_ctrl.out_last = 1'b1;
                        n_state = fpqr_pkg::ST_IDLE;
                    end else begin
                        // a full burst that lands on the end still emits the end entry
                        o_ctrl.rd_emit  = 1'b1;
                        o_ctrl.out_last = (r_cnt == fpqr_pkg::BurstW'(fpqr_pkg::ReadBurst - 1))
                                          && !i_stat.rd_next_end;
                        n_cnt = r_cnt + 1'b1;
                        n_state = o_ctrl.out_last ? fpqr_pkg::ST_IDLE : fpqr_pkg::ST_RD_ADDR;
                    end
                end
            end
            default: n_state = fpqr_pkg::ST_IDLE;
        endcase
    end

endmodule

// ===== rtl/fpqr_dp.sv =====
module fpqr_dp (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  fpqr_pkg::t_ctrl  i_ctrl,
    output fpqr_pkg::t_stat  o_stat,
    input  logic [2:0]       i_cmd,
    input  logic [23:0]      i_buttons,
    input  logic [47:0]      i_sticks,
    input  logic             i_mode,
    input  logic             i_restart,
    fpqr_out_if.source       out
);

    localparam int QA = fpqr_pkg::QueueAw;
    localparam int RA = fpqr_pkg::RecAw;

    logic [23:0] r_qb [fpqr_pkg::QueueDepth];
    logic [47:0] r_qs [fpqr_pkg::QueueDepth];
    logic [71:0] r_rec_sr [fpqr_pkg::RecDepth];
    logic [7:0]  r_run [fpqr_pkg::RecDepth];

    logic [QA-1:0] r_head, r_tail;
    logic          r_zero_valid;
    logic          r_mode;
    logic [4:0]    r_starve;
    logic [RA-1:0] r_wpos, r_rpos;
    logic          r_wrapped, r_active;

    logic [23:0] r_qrd_b;
    logic [47:0] r_qrd_s;
    logic        r_qrd_zero;
    logic [71:0] r_rrd;
    logic [7:0]  r_rrd_run;

    logic        r_ov;
    logic [1:0]  r_kind;
    logic [23:0] r_ob;
    logic [47:0] r_os;
    logic [7:0]  r_orun;
    logic        r_olast, r_omore, r_oacc;

    logic [QA-1:0] nh;
    logic          full, do_push;
    logic [23:0]   push_b;
    logic [47:0]   push_s;
    logic [23:0]   cur_b;
    logic [47:0]   cur_s;
    logic          same;
    logic [RA-1:0] w_next;
    logic [RA-1:0] rpos_next;
    logic [RA-1:0] rpos_start;

    assign nh      = r_head + 1'b1;
    assign full    = (nh == r_tail);
    assign do_push = (i_ctrl.push_user || i_ctrl.push_neutral) && !full;
    assign push_b  = i_ctrl.push_neutral ? 24'd0 : i_buttons;
    assign push_s  = i_ctrl.push_neutral ? fpqr_pkg::NeutralSticks :
                     (fpqr_pkg::t_cmd'(i_cmd) == fpqr_pkg::CMD_QUEUE_DIGITAL) ?
                     fpqr_pkg::NeutralSticks : i_sticks;
    // entry 0 keeps its reset value until first written
    assign cur_b   = r_qrd_zero ? 24'd0 : r_qrd_b;
    assign cur_s   = r_qrd_zero ? fpqr_pkg::NeutralSticks : r_qrd_s;
    assign same    = (r_rrd_run < fpqr_pkg::RunCap) && (r_rrd == {cur_b, cur_s});
    assign w_next  = r_wpos + 1'b1;
    assign rpos_next  = r_rpos + 1'b1;
    assign rpos_start = r_wrapped ? w_next : '0;

    assign o_stat.starved     = (r_starve > fpqr_pkg::StarveLimit);
    assign o_stat.rec_active  = r_active;
    assign o_stat.rd_at_end   = (r_rpos == r_wpos);
    assign o_stat.rd_next_end = (rpos_next == r_wpos);
    assign o_stat.out_busy    = r_ov && !out.ready;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_qb[r_head] <= push_b;
            r_qs[r_head] <= push_s;
        end
        r_qrd_b <= r_qb[r_tail];
        r_qrd_s <= r_qs[r_tail];
        if (i_ctrl.seed) begin
            r_rec_sr[0] <= {cur_b, cur_s};
            r_run[0]    <= 8'd1;
        end else if (i_ctrl.rec_write) begin
            if (same) begin
                r_run[r_wpos] <= r_rrd_run + 1'b1;
            end else begin
                r_rec_sr[w_next] <= {cur_b, cur_s};
                r_run[w_next]    <= 8'd1;
            end
        end
        // read data holds while a result waits
        if (i_ctrl.rd_issue) begin
            r_rrd     <= r_rec_sr[r_rpos];
            r_rrd_run <= r_run[r_rpos];
        end else if (i_ctrl.rec_read) begin
            r_rrd     <= r_rec_sr[r_wpos];
            r_rrd_run <= r_run[r_wpos];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head       <= QA'(1);
            r_tail       <= '0;
            r_zero_valid <= 1'b0;
            r_mode       <= 1'b0;
            r_starve     <= '0;
            r_wpos       <= '0;
            r_rpos       <= '0;
            r_wrapped    <= 1'b0;
            r_active     <= 1'b0;
            r_ov         <= 1'b0;
            r_qrd_zero   <= 1'b0;
        end else begin
            r_qrd_zero <= (r_tail == '0) && !r_zero_valid;
            if (do_push) begin
                r_head <= nh;
                if (r_head == '0) r_zero_valid <= 1'b1;
            end
            if (i_ctrl.set_mode) r_mode <= i_mode;
            if (i_ctrl.push_neutral) r_mode <= 1'b0;
            if (i_ctrl.tick_sel) begin
                if (!r_mode) begin
                    r_tail   <= r_head - 1'b1;
                    r_starve <= '0;
                end else if (r_tail + 1'b1 != r_head) begin
                    r_tail   <= r_tail + 1'b1;
                    r_starve <= '0;
                end else begin
                    r_starve <= r_starve + 1'b1;
                end
            end
            if (i_ctrl.seed) begin
                r_wpos    <= '0;
                r_wrapped <= 1'b0;
                r_active  <= 1'b1;
            end
            if (i_ctrl.stop_rec) r_active <= 1'b0;
            if (i_ctrl.rec_write && !same) begin
                r_wpos <= w_next;
                if (w_next == '0) r_wrapped <= 1'b1;
            end
            if (i_ctrl.rd_start && i_restart) r_rpos <= rpos_start;
            if (i_ctrl.rd_emit && !i_ctrl.rd_last) r_rpos <= rpos_next;

            if (out.ready) r_ov <= 1'b0;
            if (i_ctrl.status_out || i_ctrl.show_frame || i_ctrl.rd_emit) r_ov <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.status_out) begin
            r_kind  <= fpqr_pkg::KIND_STATUS;
            r_ob    <= '0;
            r_os    <= '0;
            r_orun  <= '0;
            r_olast <= 1'b1;
            r_omore <= 1'b0;
            r_oacc  <= do_push;
        end else if (i_ctrl.show_frame) begin
            r_kind  <= fpqr_pkg::KIND_FRAME;
            r_ob    <= cur_b;
            r_os    <= cur_s;
            r_orun  <= '0;
            r_olast <= 1'b1;
            r_omore <= 1'b0;
            r_oacc  <= 1'b0;
        end else if (i_ctrl.rd_emit) begin
            r_kind  <= fpqr_pkg::KIND_REC;
            r_ob    <= r_rrd[71:48];
            r_os    <= r_rrd[47:0];
            r_orun  <= r_rrd_run;
            r_olast <= i_ctrl.out_last;
            r_omore <= i_ctrl.out_last && !i_ctrl.rd_last;
            r_oacc  <= 1'b0;
        end
    end

    assign out.valid            = r_ov;
    assign out.kind             = r_kind;
    assign out.buttons_out      = r_ob;
    assign out.sticks_out       = r_os;
    assign out.run_count        = r_orun;
    assign out.last_of_burst    = r_olast;
    assign out.more_pending     = r_omore;
    assign out.push_accepted    = r_oacc;
    assign out.queue_free       = 8'(r_tail - r_head - 1'b1);
    assign out.record_remaining = r_wrapped ? 13'd0 :
                                  13'(fpqr_pkg::RecDepth) - {1'b0, r_wpos};
    assign out.buffered_mode    = r_mode;
    assign out.recording_on     = r_active;

endmodule

// ===== rtl/frame_playback_queue_recorder_unit.sv =====
// Frame playback queue with run-length recorder. Queue, mode, stop and no-op
// requests are answered from the idle state; a frame tick passes queue select,
// table read and show, with the recording read-modify-write before the show
// when recording; start recording reads the queue, then seeds the recording; a
// readout emits each entry after its registered recording memory read. Status
// fields on the output track live state and are valid while the result is
// presented, as the next request is only taken once the previous result has left.
module frame_playback_queue_recorder_unit (
    input  logic       i_clk,
    input  logic       i_rst_n,
    fpqr_in_if.sink    in_ch,
    fpqr_out_if.source out_ch
);

    fpqr_pkg::t_ctrl ctrl;
    fpqr_pkg::t_stat stat;

    fpqr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (in_ch.valid),
        .i_cmd      (in_ch.command),
        .o_in_ready (in_ch.ready),
        .i_stat     (stat),
        .o_ctrl     (ctrl)
    );

    fpqr_dp u_dp (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctrl    (ctrl),
        .o_stat    (stat),
        .i_cmd     (in_ch.command),
        .i_buttons (in_ch.buttons_in),
        .i_sticks  (in_ch.sticks_in),
        .i_mode    (in_ch.mode_value),
        .i_restart (in_ch.restart_read),
        .out       (out_ch)
    );

endmodule

// ===== rtl/fpqr_checker.sv =====
module fpqr_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [1:0]  out_kind,
    input logic [7:0]  out_run,
    input logic        out_last,
    input logic        out_more
);

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped while stalled");

    a_run_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && out_kind == fpqr_pkg::KIND_REC |-> out_run != 8'd0 && out_run <= 8'd240)
        else $error("run count out of range");

    a_more_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && out_more |-> out_last && out_kind == fpqr_pkg::KIND_REC)
        else $error("more pending off a last readout entry");

    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_ready |-> !(out_valid && !out_ready))
        else $error("request taken while result stalled");

endmodule

bind frame_playback_queue_recorder_unit fpqr_checker u_chk (
    .i_clk     (i_clk),
    .i_rst_n   (i_rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_kind  (out_ch.kind),
    .out_run   (out_ch.run_count),
    .out_last  (out_ch.last_of_burst),
    .out_more  (out_ch.more_pending)
);

// ===== tb/sv/tb_top.sv =====
module tb_top;

    localparam int WatchLimit = 4000;
    localparam int HoldCycles = 400;

    typedef struct packed {
        logic [1:0]  kind;
        logic [23:0] buttons;
        logic [47:0] sticks;
        logic [7:0]  run;
        logic        last;
        logic        more;
        logic        acc;
        logic [7:0]  qfree;
        logic [12:0] rrem;
        logic        bufm;
        logic        recon;
    } frame_res_t;

    typedef struct {
        fpqr_pkg::t_cmd cmd;
        logic [23:0] b;
        logic [47:0] s;
        logic        m;
        logic        r;
        bit          typed;
        logic [1:0]  kind;
        logic [23:0] eb;
        logic [47:0] es;
        logic        acc;
        logic [7:0]  qf;
    } stim_row_t;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    fpqr_in_if  in_ch ();
    fpqr_out_if out_ch ();

    frame_playback_queue_recorder_unit uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .in_ch   (in_ch),
        .out_ch  (out_ch)
    );

    always #4 i_clk = ~i_clk;

    // model state
    logic [23:0] q_btn [fpqr_pkg::QueueDepth];
    logic [47:0] q_stk [fpqr_pkg::QueueDepth];
    logic [7:0]  q_head, q_tail;
    logic        m_buf;
    logic [4:0]  starve;
    logic [23:0] r_btn [fpqr_pkg::RecDepth];
    logic [47:0] r_stk [fpqr_pkg::RecDepth];
    logic [7:0]  r_run [fpqr_pkg::RecDepth];
    logic [11:0] r_wp, r_rp;
    logic        r_wrap, r_on;
    bit          rec_seeded;

    frame_res_t  frames_due [$];
    stim_row_t   dir_tab [$];
    int          fail_cnt = 0;
    int          idle_cnt = 0;
    bit          no_idle = 1'b0;
    bit          hold_req = 1'b0;

    function automatic bit queue_store(logic [23:0] b, logic [47:0] s);
        if (q_head + 8'd1 == q_tail) return 1'b0;
        q_btn[q_head] = b;
        q_stk[q_head] = s;
        q_head = q_head + 8'd1;
        return 1'b1;
    endfunction

    function automatic frame_res_t mk_res(logic [1:0] k, logic [23:0] b, logic [47:0] s,
                                          logic [7:0] run, logic acc);
        frame_res_t x;
        x = '0;
        x.kind = k; x.buttons = b; x.sticks = s; x.run = run; x.acc = acc;
        return x;
    endfunction

    task automatic predict_frames(fpqr_pkg::t_cmd cmd, logic [23:0] b, logic [47:0] s,
                                  logic m, logic rst);
        frame_res_t step_res [$];
        frame_res_t x;
        logic [11:0] w;
        int i;
        bit ok;
        case (cmd)
            fpqr_pkg::CMD_QUEUE_DIGITAL: begin
                ok = queue_store(b, fpqr_pkg::NeutralSticks);
                step_res.push_back(mk_res(fpqr_pkg::KIND_STATUS, '0, '0, '0, ok));
            end
            fpqr_pkg::CMD_QUEUE_FULL: begin
                ok = queue_store(b, s);
                step_res.push_back(mk_res(fpqr_pkg::KIND_STATUS, '0, '0, '0, ok));
            end
            fpqr_pkg::CMD_FRAME_TICK: begin
                if (starve > fpqr_pkg::StarveLimit) begin
                    ok = queue_store('0, fpqr_pkg::NeutralSticks);
                    m_buf = 1'b0;
                end
                if (!m_buf) begin
                    q_tail = q_head - 8'd1;
                    starve = '0;
                end else if (q_tail + 8'd1 != q_head) begin
                    q_tail = q_tail + 8'd1;
                    starve = '0;
                end else begin
                    starve = starve + 5'd1;
                end
                if (r_on) begin
                    w = r_wp;
                    if (r_run[w] < fpqr_pkg::RunCap && r_btn[w] == q_btn[q_tail]
                        && r_stk[w] == q_stk[q_tail]) begin
                        r_run[w] = r_run[w] + 8'd1;
                    end else begin
                        if (w == fpqr_pkg::RecDepth - 1) r_wrap = 1'b1;
                        w = w + 12'd1;
                        r_wp = w;
                        r_btn[w] = q_btn[q_tail];
                        r_stk[w] = q_stk[q_tail];
                        r_run[w] = 8'd1;
                    end
                end
                step_res.push_back(mk_res(fpqr_pkg::KIND_FRAME, q_btn[q_tail], q_stk[q_tail],
                                          '0, 1'b0));
            end
            fpqr_pkg::CMD_SET_MODE: begin
                m_buf = m;
                step_res.push_back(mk_res(fpqr_pkg::KIND_STATUS, '0, '0, '0, 1'b0));
            end
            fpqr_pkg::CMD_START_REC: begin
                r_wp = '0; r_wrap = 1'b0;
                r_btn[0] = q_btn[q_tail];
                r_stk[0] = q_stk[q_tail];
                r_run[0] = 8'd1;
                r_on = 1'b1;
                rec_seeded = 1'b1;
                step_res.push_back(mk_res(fpqr_pkg::KIND_STATUS, '0, '0, '0, 1'b0));
            end
            fpqr_pkg::CMD_STOP_REC: begin
                r_on = 1'b0;
                step_res.push_back(mk_res(fpqr_pkg::KIND_STATUS, '0, '0, '0, 1'b0));
            end
            fpqr_pkg::CMD_READ_REC: begin
                if (rst) r_rp = r_wrap ? r_wp + 12'd1 : 12'd0;
                i = 0;
                while (i < fpqr_pkg::ReadBurst && r_rp != r_wp) begin
                    step_res.push_back(mk_res(fpqr_pkg::KIND_REC, r_btn[r_rp], r_stk[r_rp],
                                              r_run[r_rp], 1'b0));
                    r_rp = r_rp + 12'd1;
                    i++;
                end
                if (r_rp == r_wp)
                    step_res.push_back(mk_res(fpqr_pkg::KIND_REC, r_btn[r_rp], r_stk[r_rp],
                                              r_run[r_rp], 1'b0));
                else
                    step_res[$].more = 1'b1;
            end
            default: step_res.push_back(mk_res(fpqr_pkg::KIND_STATUS, '0, '0, '0, 1'b0));
        endcase
        foreach (step_res[j]) begin
            x = step_res[j];
            x.last  = (j == step_res.size() - 1);
            x.qfree = q_tail - q_head - 8'd1;
            x.rrem  = r_wrap ? 13'd0 : 13'(fpqr_pkg::RecDepth) - {1'b0, r_wp};
            x.bufm  = m_buf;
            x.recon = r_on;
            frames_due.push_back(x);
        end
    endtask

    task automatic send(fpqr_pkg::t_cmd cmd, logic [23:0] b, logic [47:0] s, logic m,
                        logic rst);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 3);
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid        <= 1'b1;
        in_ch.command      <= cmd;
        in_ch.buttons_in   <= b;
        in_ch.sticks_in    <= s;
        in_ch.mode_value   <= m;
        in_ch.restart_read <= rst;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        predict_frames(cmd, b, s, m, rst);
    endtask

    // never let a readout walk into entries the current recording did not write
    task automatic send_read(logic rst);
        if (!rec_seeded) return;
        if (!rst && !r_wrap && r_rp > r_wp) rst = 1'b1;
        send(fpqr_pkg::CMD_READ_REC, 24'($urandom), '0, 1'($urandom), rst);
    endtask

    function automatic logic [47:0] rnd48();
        return {16'($urandom), 32'($urandom)};
    endfunction

    function automatic void add_row(fpqr_pkg::t_cmd c, logic [23:0] b, logic [47:0] s,
                                    logic m, logic r, bit typed = 1'b0,
                                    logic [1:0] k = '0, logic [23:0] eb = '0,
                                    logic [47:0] es = '0, logic acc = 1'b0,
                                    logic [7:0] qf = '0);
        stim_row_t row;
        row.cmd = c; row.b = b; row.s = s; row.m = m; row.r = r;
        row.typed = typed; row.kind = k; row.eb = eb; row.es = es;
        row.acc = acc; row.qf = qf;
        dir_tab.push_back(row);
    endfunction

    function automatic void check_field(string name, logic [63:0] e, logic [63:0] a);
        if (e !== a) begin
            $error("%s: expected %0h, got %0h", name, e, a);
            fail_cnt++;
        end
    endfunction

    always @(posedge i_clk) begin
        frame_res_t e;
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle_cnt <= 0;
        else idle_cnt <= idle_cnt + 1;
        if (idle_cnt > WatchLimit) begin
            $display("RESULT: ERROR");
            $finish;
        end
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (frames_due.size() == 0) begin
                $error("result with nothing expected");
                fail_cnt++;
            end else begin
                e = frames_due.pop_front();
                check_field("kind", 64'(e.kind), 64'(out_ch.kind));
                check_field("buttons_out", 64'(e.buttons), 64'(out_ch.buttons_out));
                check_field("sticks_out", 64'(e.sticks), 64'(out_ch.sticks_out));
                check_field("run_count", 64'(e.run), 64'(out_ch.run_count));
                check_field("last_of_burst", 64'(e.last), 64'(out_ch.last_of_burst));
                check_field("more_pending", 64'(e.more), 64'(out_ch.more_pending));
                check_field("push_accepted", 64'(e.acc), 64'(out_ch.push_accepted));
                check_field("queue_free", 64'(e.qfree), 64'(out_ch.queue_free));
                check_field("record_remaining", 64'(e.rrem), 64'(out_ch.record_remaining));
                check_field("buffered_mode", 64'(e.bufm), 64'(out_ch.buffered_mode));
                check_field("recording_on", 64'(e.recon), 64'(out_ch.recording_on));
            end
        end
    end

    // result side
    initial begin
        int w;
        out_ch.ready <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (hold_req) begin
                out_ch.ready <= 1'b0;
                repeat (HoldCycles) @(posedge i_clk);
                hold_req = 1'b0;
            end
            w = no_idle ? 0 : $urandom_range(0, 3);
            if (w > 0) begin
                out_ch.ready <= 1'b0;
                repeat (w) @(posedge i_clk);
            end
            out_ch.ready <= 1'b1;
            @(posedge i_clk);
            while (!out_ch.valid && !hold_req) @(posedge i_clk);
        end
    end

    initial begin
        int pick;
        logic [23:0] b;
        in_ch.valid        <= 1'b0;
        in_ch.command      <= fpqr_pkg::CMD_NOP;
        in_ch.buttons_in   <= '0;
        in_ch.sticks_in    <= '0;
        in_ch.mode_value   <= 1'b0;
        in_ch.restart_read <= 1'b0;

        foreach (q_btn[i]) begin q_btn[i] = '0; q_stk[i] = '0; end
        q_stk[0] = fpqr_pkg::NeutralSticks;
        q_head = 8'd1; q_tail = '0; m_buf = 1'b0; starve = '0;
        r_wp = '0; r_rp = '0; r_wrap = 1'b0; r_on = 1'b0; rec_seeded = 1'b0;

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        add_row(fpqr_pkg::CMD_FRAME_TICK, 24'hFFFFFF, '1, 1'b1, 1'b1, 1'b1,
                fpqr_pkg::KIND_FRAME, 24'd0, fpqr_pkg::NeutralSticks, 1'b0, 8'd254);
        add_row(fpqr_pkg::CMD_QUEUE_DIGITAL, 24'hFFFFFF, '1, 1'b0, 1'b0, 1'b1,
                fpqr_pkg::KIND_STATUS, 24'd0, 48'd0, 1'b1, 8'd253);
        add_row(fpqr_pkg::CMD_QUEUE_FULL, 24'h000000, '1, 1'b1, 1'b1, 1'b1,
                fpqr_pkg::KIND_STATUS, 24'd0, 48'd0, 1'b1, 8'd252);
        add_row(fpqr_pkg::CMD_FRAME_TICK, '0, '0, 1'b0, 1'b0, 1'b1,
                fpqr_pkg::KIND_FRAME, 24'h000000, '1, 1'b0, 8'd254);
        add_row(fpqr_pkg::CMD_SET_MODE, '0, '0, 1'b1, 1'b0);
        add_row(fpqr_pkg::CMD_FRAME_TICK, '0, '0, 1'b0, 1'b0);
        add_row(fpqr_pkg::CMD_START_REC, '0, '0, 1'b0, 1'b0);
        add_row(fpqr_pkg::CMD_QUEUE_FULL, 24'h123456, 48'h0, 1'b0, 1'b0);
        add_row(fpqr_pkg::CMD_QUEUE_DIGITAL, 24'hA5A5A5, 48'h0, 1'b0, 1'b0);
        add_row(fpqr_pkg::CMD_FRAME_TICK, '0, '0, 1'b0, 1'b0);
        add_row(fpqr_pkg::CMD_FRAME_TICK, '0, '0, 1'b0, 1'b0);
        add_row(fpqr_pkg::CMD_FRAME_TICK, '0, '0, 1'b0, 1'b0);
        add_row(fpqr_pkg::CMD_READ_REC, '0, '0, 1'b0, 1'b1);
        add_row(fpqr_pkg::CMD_READ_REC, '0, '0, 1'b0, 1'b0);
        add_row(fpqr_pkg::CMD_SET_MODE, '0, '0, 1'b0, 1'b0);
        add_row(fpqr_pkg::CMD_QUEUE_FULL, 24'h800001, 48'h8000_0000_0001, 1'b0, 1'b0);
        add_row(fpqr_pkg::CMD_FRAME_TICK, '0, '0, 1'b0, 1'b0);
        add_row(fpqr_pkg::CMD_STOP_REC, '0, '0, 1'b0, 1'b0);
        add_row(fpqr_pkg::CMD_FRAME_TICK, '0, '0, 1'b0, 1'b0);
        add_row(fpqr_pkg::CMD_NOP, 24'hFFFFFF, '1, 1'b1, 1'b1, 1'b1,
                fpqr_pkg::KIND_STATUS, 24'd0, 48'd0, 1'b0, 8'd254);
        add_row(fpqr_pkg::CMD_READ_REC, '0, '0, 1'b0, 1'b1);

        foreach (dir_tab[i]) begin
            if (dir_tab[i].cmd == fpqr_pkg::CMD_READ_REC) begin
                send_read(dir_tab[i].r);
            end else begin
                send(dir_tab[i].cmd, dir_tab[i].b, dir_tab[i].s, dir_tab[i].m, dir_tab[i].r);
                if (dir_tab[i].typed) begin
                    frames_due[$].kind    = dir_tab[i].kind;
                    frames_due[$].buttons = dir_tab[i].eb;
                    frames_due[$].sticks  = dir_tab[i].es;
                    frames_due[$].acc     = dir_tab[i].acc;
                    frames_due[$].qfree   = dir_tab[i].qf;
                end
            end
        end

        // buffered with an empty queue until the forced neutral push
        send(fpqr_pkg::CMD_SET_MODE, '0, '0, 1'b1, 1'b0);
        repeat (23) send(fpqr_pkg::CMD_FRAME_TICK, '0, '0, 1'b0, 1'b0);

        // stall results while requests keep coming
        hold_req = 1'b1;
        no_idle = 1'b1;
        repeat (30) send(fpqr_pkg::CMD_QUEUE_FULL, 24'($urandom), rnd48(), 1'b0, 1'b0);
        no_idle = 1'b0;
        send(fpqr_pkg::CMD_SET_MODE, '0, '0, 1'b1, 1'b0);

        for (int n = 0; n < 180; n++) begin
            if (n % 64 == 40) no_idle = 1'b1;
            if (n % 64 == 56) no_idle = 1'b0;
            b = ($urandom_range(0, 3) == 0) ? 24'h0000AA : 24'($urandom);
            pick = $urandom_range(0, 99);
            if (pick < 25)
                send(fpqr_pkg::CMD_QUEUE_DIGITAL, b, rnd48(), 1'($urandom), 1'($urandom));
            else if (pick < 45)
                send(fpqr_pkg::CMD_QUEUE_FULL, b, rnd48(), 1'($urandom), 1'($urandom));
            else if (pick < 78)
                send(fpqr_pkg::CMD_FRAME_TICK, b, rnd48(), 1'($urandom), 1'($urandom));
            else if (pick < 83)
                send(fpqr_pkg::CMD_SET_MODE, b, rnd48(), 1'($urandom), 1'($urandom));
            else if (pick < 87)
                send(fpqr_pkg::CMD_START_REC, b, rnd48(), 1'($urandom), 1'($urandom));
            else if (pick < 89)
                send(fpqr_pkg::CMD_STOP_REC, b, rnd48(), 1'($urandom), 1'($urandom));
            else if (pick < 97)
                send_read(1'($urandom));
            else
                send(fpqr_pkg::CMD_NOP, b, rnd48(), 1'($urandom), 1'($urandom));
        end

        in_ch.valid <= 1'b0;
        while (frames_due.size() != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        if (fail_cnt == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/fpqr_pkg.sv
rtl/fpqr_if.sv
rtl/fpqr_ctrl.sv
rtl/fpqr_dp.sv
rtl/frame_playback_queue_recorder_unit.sv
rtl/fpqr_checker.sv
tb/sv/tb_top.sv
